[rtl/core/sto_pkg.sv]
// Shared sizes, codes and types of the sorted timeout queue.
`timescale 1ns / 1ps

package sto_pkg;

    localparam int CAPACITY  = 16;
    localparam int REF_BITS  = 16;
    localparam int TIME_BITS = 32;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam int OP_W    = 3;
    localparam int DUR_W   = 16;
    localparam int CREF_W  = 16;
    localparam int KIND_W  = 2;
    localparam int REFO_W  = 16;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_ARM    = 3'd1;
    localparam logic [OP_W-1:0] OP_CANCEL = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
    localparam logic [OP_W-1:0] OP_START  = 3'd4;

    localparam logic [KIND_W-1:0] KIND_ASSIGNED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL     = 2'd2;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [REF_BITS-1:0]  t_ref;

    typedef struct packed {
        t_time deadline;
        t_ref  ref_id;
    } t_entry;

endpackage

[rtl/core/sto_in_if.sv]
// Input channel of the sorted timeout queue: one command item per handshake.
`timescale 1ns / 1ps

interface sto_in_if import sto_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [DUR_W-1:0]  duration;
    logic [CREF_W-1:0] cancel_ref;

    modport source (output valid, output operation, output duration, output cancel_ref,
                    input ready);
    modport sink (input valid, input operation, input duration, input cancel_ref,
                  output ready);
endinterface

[rtl/core/sto_out_if.sv]
// Result channel of the sorted timeout queue: one result item per handshake.
`timescale 1ns / 1ps

interface sto_out_if import sto_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [REFO_W-1:0] ref_out;
    logic              last;

    modport source (output valid, output kind, output ref_out, output last, input ready);
    modport sink (input valid, input kind, input ref_out, input last, output ready);
endinterface

[rtl/core/sorted_timeout_queue.sv]
// Sorted timeout queue: deadline-ordered table walked by one shared comparator.
//
//   channel   direction  payload                          handshake
//   i_in      in         operation, duration, cancel_ref  valid / ready
//   o_out     out        kind, ref_out, last              valid / ready
//
// Each table walk reads an entry from memory, then compares it and writes,
// using one shared magnitude comparator and a table memory with one write port and
// one registered read port. A new command is accepted only in the idle state, after
// the previous one has finished its walk and handed over its result, if any.
// Reset is synchronous; the table needs no clearing, since only the first count
// entries are ever read. A stalled output holds the walk before its next expiry.
`timescale 1ns / 1ps

module sorted_timeout_queue import sto_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sto_in_if.sink    i_in,
    sto_out_if.source o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_EV    = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_INS  = 2'd1;
    localparam logic [1:0] MODE_CAN  = 2'd2;

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_mode, n_mode;
    t_time             r_now, n_now;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_wr, n_wr;
    t_ref              r_next_ref, n_next_ref;
    logic              r_running, n_running;
    t_time             r_new_dl, n_new_dl;
    t_ref              r_cref, n_cref;

    logic              r_pend_valid, n_pend_valid;
    logic [KIND_W-1:0] r_pend_kind, n_pend_kind;
    t_ref              r_pend_ref, n_pend_ref;

    logic              r_out_valid;
    logic [KIND_W-1:0] r_out_kind;
    logic [REFO_W-1:0] r_out_ref;
    logic              r_out_last;

    t_entry            r_mem [CAPACITY];
    t_entry            r_rd_data;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_entry            mem_wdata;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    logic              push;
    logic [KIND_W-1:0] push_kind;
    t_ref              push_ref;
    logic              push_last;
    logic              can_push;

    t_time             cmp_a, cmp_b;
    logic              cmp_lt;
    t_ref              arm_ref;
    logic [CNT_W-1:0]  idx_dec;
    t_entry            new_entry;

    assign can_push  = !r_out_valid || o_out.ready;
    assign idx_dec   = r_idx - 1'b1;
    assign new_entry = '{deadline: r_new_dl, ref_id: r_next_ref};
    assign arm_ref   = ((r_next_ref + 1'b1) == '0) ? t_ref'(1) : t_ref'(r_next_ref + 1'b1);

    // The one magnitude comparator, shared by sorted insert and expiry.
    always_comb begin
        if (r_mode == MODE_INS) begin
            cmp_a = r_new_dl;
            cmp_b = r_rd_data.deadline;
        end else begin
            cmp_a = r_rd_data.deadline;
            cmp_b = r_now;
        end
        cmp_lt = cmp_a < cmp_b;
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_now        = r_now;
        n_count      = r_count;
        n_idx        = r_idx;
        n_wr         = r_wr;
        n_next_ref   = r_next_ref;
        n_running    = r_running;
        n_new_dl     = r_new_dl;
        n_cref       = r_cref;
        n_pend_valid = r_pend_valid;
        n_pend_kind  = r_pend_kind;
        n_pend_ref   = r_pend_ref;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = r_rd_data;
        rd_en        = 1'b0;
        rd_addr      = '0;
        push         = 1'b0;
        push_kind    = r_pend_kind;
        push_ref     = r_pend_ref;
        push_last    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.operation)
                        OP_TICK: begin
                            n_now   = r_now + 1'b1;
                            n_mode  = MODE_TICK;
                            n_idx   = '0;
                            n_wr    = '0;
                            n_state = S_RD;
                        end
                        OP_ARM: begin
                            if (!r_running) begin
                                n_pend_valid = 1'b1;
                                n_pend_kind  = KIND_ASSIGNED;
                                n_pend_ref   = '0;
                                n_state      = S_FLUSH;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                n_pend_valid = 1'b1;
                                n_pend_kind  = KIND_FULL;
                                n_pend_ref   = '0;
                                n_state      = S_FLUSH;
                            end else begin
                                n_next_ref = arm_ref;
                                n_new_dl   = r_now + t_time'(i_in.duration);
                                n_idx      = r_count;
                                n_mode     = MODE_INS;
                                n_state    = S_RD;
                            end
                        end
                        OP_CANCEL: begin
                            if (i_in.cancel_ref != '0) begin
                                n_cref  = t_ref'(i_in.cancel_ref);
                                n_mode  = MODE_CAN;
                                n_idx   = '0;
                                n_wr    = '0;
                                n_state = S_RD;
                            end
                        end
                        OP_STOP: begin
                            n_count   = '0;
                            n_running = 1'b0;
                        end
                        OP_START: begin
                            n_running = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_RD: begin
                if (r_mode == MODE_INS) begin
                    if (r_idx == '0) begin
                        mem_we       = 1'b1;
                        mem_waddr    = '0;
                        mem_wdata    = new_entry;
                        n_count      = r_count + 1'b1;
                        n_pend_valid = 1'b1;
                        n_pend_kind  = KIND_ASSIGNED;
                        n_pend_ref   = r_next_ref;
                        n_state      = S_FLUSH;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = idx_dec[IDX_W-1:0];
                        n_state = S_EV;
                    end
                end else if (r_idx == r_count) begin
                    n_count = r_wr;
                    n_state = S_FLUSH;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[IDX_W-1:0];
                    n_state = S_EV;
                end
            end

            S_EV: begin
                case (r_mode)
                    MODE_INS: begin
                        mem_we    = 1'b1;
                        mem_waddr = r_idx[IDX_W-1:0];
                        if (cmp_lt) begin
                            // The stored entry is later than the new one: move it up.
                            mem_wdata = r_rd_data;
                            n_idx     = idx_dec;
                            n_state   = S_RD;
                        end else begin
                            mem_wdata    = new_entry;
                            n_count      = r_count + 1'b1;
                            n_pend_valid = 1'b1;
                            n_pend_kind  = KIND_ASSIGNED;
                            n_pend_ref   = r_next_ref;
                            n_state      = S_FLUSH;
                        end
                    end
                    MODE_TICK: begin
                        if (cmp_lt) begin
                            // An expiry is held as pending so the final one can carry last.
                            if (!r_pend_valid || can_push) begin
                                push         = r_pend_valid;
                                n_pend_valid = 1'b1;
                                n_pend_kind  = KIND_EXPIRED;
                                n_pend_ref   = r_rd_data.ref_id;
                                n_idx        = r_idx + 1'b1;
                                n_state      = S_RD;
                            end
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_wr[IDX_W-1:0];
                            n_wr      = r_wr + 1'b1;
                            n_idx     = r_idx + 1'b1;
                            n_state   = S_RD;
                        end
                    end
                    MODE_CAN: begin
                        if (r_rd_data.ref_id != r_cref) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_wr[IDX_W-1:0];
                            n_wr      = r_wr + 1'b1;
                        end
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (can_push) begin
                    push         = 1'b1;
                    push_last    = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= MODE_TICK;
            r_now        <= '0;
            r_count      <= '0;
            r_idx        <= '0;
            r_wr         <= '0;
            r_next_ref   <= '0;
            r_running    <= 1'b1;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_now        <= n_now;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_wr         <= n_wr;
            r_next_ref   <= n_next_ref;
            r_running    <= n_running;
            r_pend_valid <= n_pend_valid;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_new_dl    <= n_new_dl;
        r_cref      <= n_cref;
        r_pend_kind <= n_pend_kind;
        r_pend_ref  <= n_pend_ref;
        if (push) begin
            r_out_kind <= push_kind;
            r_out_ref  <= REFO_W'(push_ref);
            r_out_last <= push_last;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.kind    = r_out_kind;
    assign o_out.ref_out = r_out_ref;
    assign o_out.last    = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds the table size");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind != KIND_EXPIRED) |-> o_out.last)
        else $error("an arm result must be the only result of its item");

    a_full_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_FULL) |-> (o_out.ref_out == '0))
        else $error("a rejected arm must carry a zero reference");

    a_arm_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.operation == OP_ARM) |=> (r_state != S_IDLE))
        else $error("an accepted arm must leave the idle state");

endmodule
